// ===== rtl/core/rsa_pkg.sv =====
// Shared types and constants for the running statistics aggregator.
package rsa_pkg;

    localparam int MAX_LEVELS = 256;
    localparam int HIST_DEPTH = MAX_LEVELS + 2;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CFG_IW     = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IW-1:0] CFG_KIND        = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_START_VALUE = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_HIST_BASE   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_HIST_STEP   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_HIST_LEVELS = 3'd4;

    typedef enum logic [2:0] {
        K_MIN   = 3'd0,
        K_MAX   = 3'd1,
        K_COUNT = 3'd2,
        K_SUM   = 3'd3,
        K_AVG   = 3'd4,
        K_SDEV  = 3'd5,
        K_HIST  = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC,
        ST_MUL0, ST_MUL1, ST_MUL2, ST_SQL, ST_SQH, ST_ACL, ST_ACH,
        ST_HDIV, ST_HIDX, ST_HRD, ST_HWR, ST_DONE
    } t_state;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic signed [63:0] sample;
        logic [63:0]        increment;
    } t_item;

    typedef struct packed {
        logic signed [63:0] start_value;
        logic signed [31:0] hist_base;
        logic [15:0]        hist_step;
        logic [8:0]         hist_levels;
    } t_cfg;

endpackage

// ===== rtl/core/rsa_front.sv =====
// Front end: input request queue, tags each request with the current kind.
module rsa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic signed [63:0] i_sample,
    input  logic [63:0]   i_increment,
    input  rsa_pkg::t_kind i_kind,
    input  logic          i_clearing,
    input  logic          i_take,
    output rsa_pkg::t_item o_item
);
    import rsa_pkg::*;

    t_item      r_q [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok;

    assign full    = (r_cnt == 2'(QUEUE_DEPTH)) || i_clearing;
    assign push_ok = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (i_take)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp].valid     <= 1'b1;
            r_q[r_wp].kind      <= i_kind;
            r_q[r_wp].sample    <= i_sample;
            r_q[r_wp].increment <= i_increment;
        end
    end

    always_comb begin
        o_item       = r_q[r_rp];
        o_item.valid = (r_cnt != 2'd0);
    end

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_cnt != 2'd0) else $error("take from empty queue");
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok && !i_take |=> r_cnt == $past(r_cnt) + 2'd1) else $error("queue count");

endmodule

// ===== rtl/core/rsa_back.sv =====
// Back end: sequencer with shared multiplier, bucket divider and histogram memory.
module rsa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsa_pkg::t_cfg      i_cfg,
    input  rsa_pkg::t_item     i_item,
    output logic               o_take,
    output logic               o_clearing,
    output logic               empty,
    input  logic               pop,
    output logic signed [63:0] o_accumulator,
    output logic [63:0]        o_event_count,
    output logic [63:0]        o_square_sum_low,
    output logic [63:0]        o_square_sum_high,
    output logic [8:0]         o_bucket_index,
    output logic [63:0]        o_bucket_total
);
    import rsa_pkg::*;

    t_state r_state, n_state;

    logic [63:0] r_hist [HIST_DEPTH];
    logic [63:0] r_rd;
    logic [HIST_AW-1:0] r_clr, r_idx, mem_addr;
    logic        mem_we;
    logic [63:0] mem_wd;

    t_item              r_item;
    logic               r_started;
    logic signed [63:0] r_rv;
    logic [63:0]        r_items, r_sq0, r_sq1;
    logic [63:0]        r_mag, r_ll, r_hh, r_mid, r_sql, r_sqh;
    logic               r_c;
    logic               r_ca;
    logic [31:0]        r_quo;
    logic [15:0]        r_rem;
    logic [4:0]         r_div_cnt;

    logic signed [63:0] r_res_acc;
    logic [63:0]        r_res_cnt, r_res_sql, r_res_sqh, r_res_btot;
    logic [8:0]         r_res_bidx;
    logic               r_out_valid;
    logic               pop_ok;

    logic signed [63:0] cur, exec_rv;
    logic               scalar_kind, stat_kind;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [15:0]        step_eff;
    logic [HIST_AW-1:0] levels_eff;
    logic [16:0]        trial;
    logic               ge;

    assign pop_ok      = pop && r_out_valid;
    assign empty       = !r_out_valid;
    assign scalar_kind = (r_item.kind <= K_SDEV);
    assign stat_kind   = (r_item.kind == K_AVG) || (r_item.kind == K_SDEV);
    assign cur         = r_started ? r_rv : i_cfg.start_value;
    assign step_eff    = (i_cfg.hist_step == 16'd0) ? 16'd1 : i_cfg.hist_step;
    assign trial       = {r_rem, r_quo[31]};
    assign ge          = trial >= {1'b0, step_eff};

    always_comb begin
        if (i_cfg.hist_levels == 9'd0)
            levels_eff = HIST_AW'(1);
        else if (i_cfg.hist_levels > 9'(MAX_LEVELS))
            levels_eff = HIST_AW'(MAX_LEVELS);
        else
            levels_eff = HIST_AW'(i_cfg.hist_levels);
    end

    always_comb begin
        unique case (r_item.kind)
            K_MIN:   exec_rv = (r_item.sample < cur) ? r_item.sample : cur;
            K_MAX:   exec_rv = (r_item.sample > cur) ? r_item.sample : cur;
            K_COUNT: exec_rv = cur + 64'sd1;
            K_SUM, K_AVG, K_SDEV: exec_rv = cur + r_item.sample;
            default: exec_rv = cur;
        endcase
    end

    // one 32x32 multiplier shared over the three partial squares
    always_comb begin
        unique case (r_state)
            ST_MUL1: begin mul_a = r_mag[63:32]; mul_b = r_mag[63:32]; end
            ST_MUL2: begin mul_a = r_mag[63:32]; mul_b = r_mag[31:0];  end
            default: begin mul_a = r_mag[31:0];  mul_b = r_mag[31:0];  end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == HIST_AW'(HIST_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_item.valid) n_state = ST_EXEC;
            ST_EXEC: begin
                priority if (r_item.kind == K_SDEV) n_state = ST_MUL0;
                else if (r_item.kind == K_HIST)
                    n_state = (r_item.sample[31:0] < $unsigned(i_cfg.hist_base)
                               ^ r_item.sample[31] ^ i_cfg.hist_base[31])
                              ? ST_HRD : ST_HDIV;
                else n_state = ST_DONE;
            end
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_SQL;
            ST_SQL:  n_state = ST_SQH;
            ST_SQH:  n_state = ST_ACL;
            ST_ACL:  n_state = ST_ACH;
            ST_ACH:  n_state = ST_DONE;
            ST_HDIV: if (r_div_cnt == 5'd31) n_state = ST_HIDX;
            ST_HIDX: n_state = ST_HRD;
            ST_HRD:  n_state = ST_HWR;
            ST_HWR:  n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || pop) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_take     = (r_state == ST_IDLE) && i_item.valid;
        o_clearing = (r_state == ST_CLEAR);
        mem_we     = (r_state == ST_CLEAR) || (r_state == ST_HWR);
        mem_addr   = (r_state == ST_CLEAR) ? r_clr : r_idx;
        mem_wd     = (r_state == ST_CLEAR) ? 64'd0 : r_rd + r_item.increment;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_hist[mem_addr] <= mem_wd;
        r_rd <= r_hist[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_rv        <= '0;
            r_items     <= '0;
            r_sq0       <= '0;
            r_sq1       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + HIST_AW'(1);
            if (r_state == ST_DONE && (!r_out_valid || pop)) r_out_valid <= 1'b1;
            else if (pop_ok) r_out_valid <= 1'b0;
            if (r_state == ST_EXEC) begin
                if (scalar_kind) begin
                    r_rv      <= exec_rv;
                    r_started <= 1'b1;
                end
                if (stat_kind) r_items <= r_items + 64'd1;
            end
            if (r_state == ST_ACL) {r_ca, r_sq0} <= {1'b0, r_sq0} + {1'b0, r_sql};
            if (r_state == ST_ACH) r_sq1 <= r_sq1 + r_sqh + 64'(r_ca);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: r_item <= i_item;
            ST_EXEC: begin
                r_res_acc  <= scalar_kind ? exec_rv : 64'sd0;
                r_res_cnt  <= stat_kind ? r_items + 64'd1 : 64'd0;
                r_res_sql  <= '0;
                r_res_sqh  <= '0;
                r_res_bidx <= '0;
                r_res_btot <= '0;
                r_mag      <= r_item.sample[63] ? 64'(-r_item.sample) : r_item.sample;
                r_quo      <= r_item.sample[31:0] - i_cfg.hist_base;
                r_rem      <= '0;
                r_div_cnt  <= '0;
                r_idx      <= '0;
            end
            ST_MUL0: r_ll  <= mul_p;
            ST_MUL1: r_hh  <= mul_p;
            ST_MUL2: r_mid <= mul_p;
            // square = {hh, ll} + 2 * mid * 2^32
            ST_SQL: {r_c, r_sql} <= {1'b0, r_ll} + {1'b0, r_mid[30:0], 33'd0};
            ST_SQH: r_sqh <= r_hh + 64'(r_mid[63:31]) + 64'(r_c);
            ST_ACH: begin
                r_res_sql <= r_sq0;
                r_res_sqh <= r_sq1 + r_sqh + 64'(r_ca);
            end
            ST_HDIV: begin
                r_rem     <= ge ? 16'(trial - {1'b0, step_eff}) : trial[15:0];
                r_quo     <= {r_quo[30:0], ge};
                r_div_cnt <= r_div_cnt + 5'd1;
            end
            ST_HIDX: r_idx <= (r_quo < 32'(levels_eff)) ? r_quo[HIST_AW-1:0] + HIST_AW'(1)
                                                        : levels_eff + HIST_AW'(1);
            ST_HWR: begin
                r_res_bidx <= 9'(r_idx);
                r_res_btot <= mem_wd;
            end
            ST_DONE: if (!r_out_valid || pop) begin
                o_accumulator     <= r_res_acc;
                o_event_count     <= r_res_cnt;
                o_square_sum_low  <= r_res_sql;
                o_square_sum_high <= r_res_sqh;
                o_bucket_index    <= r_res_bidx;
                o_bucket_total    <= r_res_btot;
            end
            default: ;
        endcase
    end

    a_clear_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_take) else $error("request taken during clear");
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HDIV && $past(r_state) == ST_HDIV
        |-> r_div_cnt == $past(r_div_cnt) + 5'd1) else $error("divider step");
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HRD |-> r_idx <= HIST_AW'(MAX_LEVELS + 1)) else $error("bucket range");

endmodule

// ===== rtl/core/running_statistics_aggregator.sv =====
// Top level of the running statistics aggregator: config registers and front/back.
//
// Requests enter through a queue-like port: sample and increment are taken at
// a clock edge with push high and full low. Results leave the same way: while
// empty is low the oldest result is on the o_ ports and pop takes it.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data, one
// register per cycle with no wait; the user must write it only while the
// block is idle, as the block itself does not enforce this. A two-entry
// request queue decouples the front from the back sequencer.
// Min, max, count, sum and average finish in the execute step; standard
// deviation adds three passes of one 32x32 multiplier plus 128-bit adds
// split in halves; the histogram adds the one-bit-per-cycle 32-bit bucket
// divide and the read/write of the bucket memory. Requests are handled
// one at a time; a new one is taken only after the last one is done.
// After reset the histogram memory is cleared, one bucket per cycle, all
// 258 buckets; full stays high meanwhile. A held result waits in the output
// register while the back end finishes the next request, then stalls.
module running_statistics_aggregator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [63:0] i_sample,
    input  logic [63:0]        i_increment,
    output logic               empty,
    input  logic               pop,
    output logic signed [63:0] o_accumulator,
    output logic [63:0]        o_event_count,
    output logic [63:0]        o_square_sum_low,
    output logic [63:0]        o_square_sum_high,
    output logic [8:0]         o_bucket_index,
    output logic [63:0]        o_bucket_total,
    input  logic               i_cfg_we,
    input  logic [rsa_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);
    import rsa_pkg::*;

    t_kind r_kind;
    t_cfg  r_cfg;
    t_item item;
    logic  take, clearing;

    // config register file, reset to documented defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind            <= K_MIN;
            r_cfg.start_value <= '0;
            r_cfg.hist_base   <= '0;
            r_cfg.hist_step   <= 16'd1;
            r_cfg.hist_levels <= 9'(MAX_LEVELS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KIND:        r_kind            <= t_kind'(i_cfg_data[2:0]);
                CFG_START_VALUE: r_cfg.start_value <= i_cfg_data;
                CFG_HIST_BASE:   r_cfg.hist_base   <= i_cfg_data[31:0];
                CFG_HIST_STEP:   r_cfg.hist_step   <= i_cfg_data[15:0];
                CFG_HIST_LEVELS: r_cfg.hist_levels <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    rsa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_sample   (i_sample),
        .i_increment(i_increment),
        .i_kind     (r_kind),
        .i_clearing (clearing),
        .i_take     (take),
        .o_item     (item)
    );

    rsa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_item           (item),
        .o_take           (take),
        .o_clearing       (clearing),
        .empty            (empty),
        .pop              (pop),
        .o_accumulator    (o_accumulator),
        .o_event_count    (o_event_count),
        .o_square_sum_low (o_square_sum_low),
        .o_square_sum_high(o_square_sum_high),
        .o_bucket_index   (o_bucket_index),
        .o_bucket_total   (o_bucket_total)
    );

endmodule
